// File: hdl/arat_pkg.sv
// ----------------------------------------------------------------------------
// Address range table package
// Shared sizes, codes and the records that travel along the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none
package arat_pkg;

  // Number of table slots, one cell for each.
  localparam int ENTRIES = 64;
  localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  // Width used to compare a 6-bit handle against a slot number.
  localparam int HCMP_W  = 11;

  // Opcodes.
  localparam logic [2:0] OP_REGISTER   = 3'd0;
  localparam logic [2:0] OP_UNREGISTER = 3'd1;
  localparam logic [2:0] OP_FIND       = 3'd2;
  localparam logic [2:0] OP_FIRST      = 3'd3;
  localparam logic [2:0] OP_EMPTY      = 3'd4;
  localparam logic [2:0] OP_NEXT       = 3'd5;

  // Status codes.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_EXISTS     = 3'd1;
  localparam logic [2:0] ST_FULL       = 3'd2;
  localparam logic [2:0] ST_OUTSIDE    = 3'd3;
  localparam logic [2:0] ST_BAD_HANDLE = 3'd4;

  // Search mode of a sweep along the chain.
  typedef enum logic [2:0] {
    MD_DUP,   // valid entry whose start equals the address
    MD_FIND,  // lowest start among entries that contain the address
    MD_GE,    // lowest start at or above the address
    MD_LE,    // highest start at or below the upper bound
    MD_GT     // lowest start strictly above the current entry's start
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_FINISH
  } state_t;

  // Query broadcast to every cell during a sweep.
  typedef struct packed {
    mode_t               mode;
    logic [63:0]         addr;
    logic [63:0]         hi;
    logic [63:0]         hbase;
    logic [HCMP_W-1:0]   hidx;
  } query_t;

  // Table write broadcast to every cell.
  typedef struct packed {
    logic              en;
    logic              set;
    logic [SLOT_W-1:0] slot;
    logic [63:0]       base;
    logic [63:0]       size;
    logic [63:0]       value;
  } wr_t;

  // Running record handed from cell to cell.
  typedef struct packed {
    logic              tok;
    logic              hit;
    logic [63:0]       hbase;
    logic [63:0]       hsize;
    logic              best_ok;
    logic [SLOT_W-1:0] best_slot;
    logic [63:0]       best_base;
    logic [63:0]       best_size;
    logic [63:0]       best_tag;
    logic              free_ok;
    logic [SLOT_W-1:0] free_slot;
  } carry_t;

endpackage
`default_nettype wire

// File: hdl/address_range_table.sv
// ----------------------------------------------------------------------------
// Address range table
// A chain of entry cells searched by a token sweep, with an APB register port.
// ----------------------------------------------------------------------------
//  channel   | handshake              | beat
//  command   | start, busy            | opcode .. adjacent_only
//  result    | done (one-cycle pulse) | status .. range_empty
//  config    | psel, penable, pwrite  | paddr, pwdata, prdata
//
// A command sweeps the record once down the chain of ENTRIES cells, one cell
// per cycle; a next command whose handle names a valid entry sweeps twice.
// busy is high from the cycle after a command beat until its result pulse.
// Reset clears every valid mark at once. The result is shown for one cycle
// and cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none
module address_range_table (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  opcode,
  input  wire logic [63:0] start_addr,
  input  wire logic [63:0] length,
  input  wire logic [63:0] range_end,
  input  wire logic [63:0] tag,
  input  wire logic [5:0]  handle,
  input  wire logic        adjacent_only,
  output logic             done,
  output logic [2:0]       status,
  output logic             found,
  output logic [5:0]       entry_handle,
  output logic [63:0]      entry_start,
  output logic [63:0]      entry_length,
  output logic [63:0]      entry_tag,
  output logic             range_empty,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  logic [63:0] region_low;
  logic [63:0] region_end;

  arat_pkg::query_t q;
  arat_pkg::wr_t    wr;
  logic             launch;
  arat_pkg::carry_t chain [arat_pkg::ENTRIES+1];

  // Register port; the low address bits are not decoded.
  assign pready = 1'b1;
  assign prdata = paddr[3] ? region_end : region_low;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_low <= 64'd0;
      region_end <= 64'd0;
    end else if (psel && penable && pwrite) begin
      if (paddr[3]) begin
        region_end <= pwdata;
      end else begin
        region_low <= pwdata;
      end
    end
  end

  // Empty record entering the first cell.
  always_comb begin
    chain[0]     = '0;
    chain[0].tok = launch;
  end

  arat_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .start_addr   (start_addr),
    .length       (length),
    .range_end    (range_end),
    .tag          (tag),
    .handle       (handle),
    .adjacent_only(adjacent_only),
    .region_low   (region_low),
    .region_end   (region_end),
    .q            (q),
    .wr           (wr),
    .launch       (launch),
    .tail         (chain[arat_pkg::ENTRIES]),
    .done         (done),
    .status       (status),
    .found        (found),
    .entry_handle (entry_handle),
    .entry_start  (entry_start),
    .entry_length (entry_length),
    .entry_tag    (entry_tag),
    .range_empty  (range_empty)
  );

  // Row of entry cells.
  for (genvar i = 0; i < arat_pkg::ENTRIES; i++) begin : g_cell
    arat_cell u_cell (
      .clk (clk),
      .rst (rst),
      .idx (arat_pkg::SLOT_W'(i)),
      .q   (q),
      .wr  (wr),
      .cin (chain[i]),
      .cout(chain[i+1])
    );
  end

endmodule
`default_nettype wire

// File: hdl/arat_cell.sv
// ----------------------------------------------------------------------------
// Address range table cell
// Holds one table entry and folds it into the record passing down the chain.
// ----------------------------------------------------------------------------
`default_nettype none
module arat_cell (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [arat_pkg::SLOT_W-1:0]  idx,
  input  wire arat_pkg::query_t             q,
  input  wire arat_pkg::wr_t                wr,
  input  wire arat_pkg::carry_t             cin,
  output arat_pkg::carry_t                  cout
);

  logic        valid;
  logic [63:0] base;
  logic [63:0] size;
  logic [63:0] value;

  logic [64:0]     end65;
  logic            cand;
  logic            better;
  logic            hit_here;
  arat_pkg::carry_t cnext;

  // Entry storage; only the valid mark is cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr.en && wr.slot == idx) begin
      valid <= wr.set;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.set && wr.slot == idx) begin
      base  <= wr.base;
      size  <= wr.size;
      value <= wr.value;
    end
  end

  // Does this entry qualify, and does it beat the best so far.
  always_comb begin
    end65 = {1'b0, base} + {1'b0, size};
    case (q.mode)
      arat_pkg::MD_DUP:  cand = valid && base == q.addr;
      arat_pkg::MD_FIND: cand = valid && q.addr >= base && {1'b0, q.addr} < end65;
      arat_pkg::MD_GE:   cand = valid && base >= q.addr;
      arat_pkg::MD_LE:   cand = valid && base <= q.hi;
      arat_pkg::MD_GT:   cand = valid && base > q.hbase;
      default:           cand = 1'b0;
    endcase
    if (q.mode == arat_pkg::MD_LE) begin
      better = !cin.best_ok || base > cin.best_base;
    end else begin
      better = !cin.best_ok || base < cin.best_base;
    end
    hit_here = valid && (arat_pkg::HCMP_W'(idx) == q.hidx);

    cnext = cin;
    if (hit_here) begin
      cnext.hit   = 1'b1;
      cnext.hbase = base;
      cnext.hsize = size;
    end
    if (cand && better) begin
      cnext.best_ok   = 1'b1;
      cnext.best_slot = idx;
      cnext.best_base = base;
      cnext.best_size = size;
      cnext.best_tag  = value;
    end
    if (!valid && !cin.free_ok) begin
      cnext.free_ok   = 1'b1;
      cnext.free_slot = idx;
    end
  end

  // Hand the record to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      cout <= '0;
    end else begin
      cout <= cnext;
    end
  end

endmodule
`default_nettype wire

// File: hdl/arat_ctrl.sv
// ----------------------------------------------------------------------------
// Address range table controller
// Takes a command beat, launches sweeps down the chain and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none
module arat_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire logic [2:0]    opcode,
  input  wire logic [63:0]   start_addr,
  input  wire logic [63:0]   length,
  input  wire logic [63:0]   range_end,
  input  wire logic [63:0]   tag,
  input  wire logic [5:0]    handle,
  input  wire logic          adjacent_only,
  input  wire logic [63:0]   region_low,
  input  wire logic [63:0]   region_end,
  output arat_pkg::query_t   q,
  output arat_pkg::wr_t      wr,
  output logic               launch,
  input  wire arat_pkg::carry_t tail,
  output logic               done,
  output logic [2:0]         status,
  output logic               found,
  output logic [5:0]         entry_handle,
  output logic [63:0]        entry_start,
  output logic [63:0]        entry_length,
  output logic [63:0]        entry_tag,
  output logic               range_empty
);

  arat_pkg::state_t state, state_next;

  logic [2:0]            op;
  logic [63:0]           addr;
  logic [63:0]           len;
  logic [63:0]           lim;
  logic [63:0]           tg;
  logic                  adj;
  logic                  hin;
  logic                  phase;
  logic [63:0]           hsize;
  arat_pkg::carry_t      fin;

  logic                  accept;
  logic                  second;
  logic [64:0]           new_end;
  logic [64:0]           fin_end;
  logic [64:0]           h_end;
  logic                  region_ok;
  logic                  first_ok;
  logic                  empty_ok;
  logic                  next_ok;

  assign accept = start && !busy;
  assign busy   = state != arat_pkg::S_IDLE;
  assign second = op == arat_pkg::OP_NEXT && !phase && hin && tail.hit;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= arat_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      arat_pkg::S_IDLE:   if (accept) state_next = arat_pkg::S_SWEEP;
      arat_pkg::S_SWEEP:  if (tail.tok && !second) state_next = arat_pkg::S_FINISH;
      arat_pkg::S_FINISH: state_next = arat_pkg::S_IDLE;
      default:            state_next = arat_pkg::S_IDLE;
    endcase
  end

  // Final checks on the gathered record.
  always_comb begin
    new_end   = {1'b0, addr} + {1'b0, len};
    fin_end   = {1'b0, fin.best_base} + {1'b0, fin.best_size};
    h_end     = {1'b0, q.hbase} + {1'b0, hsize};
    region_ok = addr >= region_low && new_end <= {1'b0, region_end};
    first_ok  = addr < lim && fin.best_ok && fin_end <= {1'b0, lim};
    empty_ok  = addr >= lim || !fin.best_ok || fin_end <= {1'b0, addr};
    next_ok   = fin.best_ok && fin.best_base < lim &&
                (!adj || h_end == {1'b0, fin.best_base});
  end

  // Control pulses.
  always_ff @(posedge clk) begin
    if (rst) begin
      launch <= 1'b0;
      done   <= 1'b0;
    end else begin
      launch <= accept || (state == arat_pkg::S_SWEEP && tail.tok && second);
      done   <= state == arat_pkg::S_FINISH;
    end
  end

  // Command capture, sweep hand-off, table write and result forming.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr.en <= 1'b0;
    end else begin
      wr.en <= state == arat_pkg::S_FINISH &&
               ((op == arat_pkg::OP_REGISTER && region_ok && !fin.best_ok && fin.free_ok) ||
                (op == arat_pkg::OP_UNREGISTER && hin && fin.hit));
    end
    if (accept) begin
      op       <= opcode;
      addr     <= start_addr;
      len      <= length;
      lim      <= range_end;
      tg       <= tag;
      adj      <= adjacent_only;
      hin      <= arat_pkg::HCMP_W'(handle) < arat_pkg::HCMP_W'(arat_pkg::ENTRIES);
      phase    <= 1'b0;
      q.addr   <= start_addr;
      q.hi     <= range_end - 64'd1;
      q.hidx   <= arat_pkg::HCMP_W'(handle);
      case (opcode)
        arat_pkg::OP_FIND:  q.mode <= arat_pkg::MD_FIND;
        arat_pkg::OP_FIRST: q.mode <= arat_pkg::MD_GE;
        arat_pkg::OP_EMPTY: q.mode <= arat_pkg::MD_LE;
        default:            q.mode <= arat_pkg::MD_DUP;
      endcase
    end
    if (state == arat_pkg::S_SWEEP && tail.tok) begin
      if (second) begin
        phase   <= 1'b1;
        q.hbase <= tail.hbase;
        hsize   <= tail.hsize;
        q.mode  <= arat_pkg::MD_GT;
      end else begin
        fin <= tail;
      end
    end
    if (state == arat_pkg::S_FINISH) begin
      status       <= arat_pkg::ST_OK;
      found        <= 1'b0;
      entry_handle <= 6'd0;
      entry_start  <= 64'd0;
      entry_length <= 64'd0;
      entry_tag    <= 64'd0;
      range_empty  <= 1'b0;
      wr.set       <= 1'b0;
      wr.slot      <= fin.free_slot;
      wr.base      <= addr;
      wr.size      <= len;
      wr.value     <= tg;
      case (op)
        arat_pkg::OP_REGISTER: begin
          if (!region_ok) begin
            status <= arat_pkg::ST_OUTSIDE;
          end else if (fin.best_ok) begin
            status       <= arat_pkg::ST_EXISTS;
            found        <= 1'b1;
            entry_handle <= 6'(fin.best_slot);
            entry_start  <= fin.best_base;
            entry_length <= fin.best_size;
            entry_tag    <= fin.best_tag;
          end else if (!fin.free_ok) begin
            status <= arat_pkg::ST_FULL;
          end else begin
            wr.set       <= 1'b1;
            entry_handle <= 6'(fin.free_slot);
            entry_start  <= addr;
            entry_length <= len;
            entry_tag    <= tg;
          end
        end
        arat_pkg::OP_UNREGISTER: begin
          if (!hin || !fin.hit) begin
            status <= arat_pkg::ST_BAD_HANDLE;
          end else begin
            wr.slot      <= arat_pkg::SLOT_W'(q.hidx);
            entry_handle <= 6'(q.hidx);
          end
        end
        arat_pkg::OP_FIND, arat_pkg::OP_FIRST, arat_pkg::OP_NEXT: begin
          if (op == arat_pkg::OP_NEXT && !phase) begin
            status <= arat_pkg::ST_BAD_HANDLE;
          end else if ((op == arat_pkg::OP_FIND && fin.best_ok) ||
                       (op == arat_pkg::OP_FIRST && first_ok) ||
                       (op == arat_pkg::OP_NEXT && next_ok)) begin
            found        <= 1'b1;
            entry_handle <= 6'(fin.best_slot);
            entry_start  <= fin.best_base;
            entry_length <= fin.best_size;
            entry_tag    <= fin.best_tag;
          end
        end
        arat_pkg::OP_EMPTY: range_empty <= empty_ok;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hdl/arat_checker.sv
// ----------------------------------------------------------------------------
// Address range table checker
// Port-level properties of the command and result channels.
// ----------------------------------------------------------------------------
`default_nettype none
module arat_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done,
  input wire logic [2:0] status,
  input wire logic       found,
  input wire logic       range_empty
);

  // An accepted command always makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("command beat did not raise busy");

  // Results never come in two adjacent cycles.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result beats back to back");

  // A result is never shown while a command is still at work.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while busy");

  // Status stays within its codes.
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> status <= arat_pkg::ST_BAD_HANDLE) else $error("bad status code");

  // The empty answer never comes with a reported entry or an error.
  a_empty_alone: assert property (@(posedge clk) disable iff (rst)
    done && range_empty |-> !found && status == arat_pkg::ST_OK)
    else $error("range_empty with entry or error");

endmodule

bind address_range_table arat_checker u_arat_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .status     (status),
  .found      (found),
  .range_empty(range_empty)
);
`default_nettype wire
